[rtl/core/pmef_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmef_pkg
// shared constants and types of the two-lane median / moving average filter
// ----------------------------------------------------------------------------
package pmef_pkg;

  localparam int WINDOW              = 5;
  localparam int POS_BITS            = $clog2(WINDOW);
  localparam int SAMPLE_BITS_DEF     = 18;
  localparam int FRACTION_BITS_DEF   = 16;
  localparam int WEIGHT_BITS         = 16;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd19661;

  // per-transaction control handed from the top level to each lane
  typedef struct packed {
    logic                step;  // commit this transaction into lane state
    logic                warm;  // ring still filling, pass the raw sample
    logic [POS_BITS-1:0] pos;   // ring slot written by this transaction
  } lane_ctrl_t;

endpackage

[rtl/core/pmef_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmef_lane
// one filter lane: 5-entry ring, median by rank, moving average, rounding
// ----------------------------------------------------------------------------
module pmef_lane import pmef_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lane_ctrl_t               ctrl,
  input  logic [SAMPLE_BITS-1:0]   sample,
  input  logic [FRACTION_BITS-1:0] weight,
  output logic [SAMPLE_BITS-1:0]   filtered
);

  localparam int AW = SAMPLE_BITS + FRACTION_BITS;
  localparam logic [AW:0] HALF = (AW+1)'(1) << (FRACTION_BITS - 1);

  logic [SAMPLE_BITS-1:0]   win_r [WINDOW];
  logic [AW-1:0]            avg_r;
  logic [AW-1:0]            avg_nxt;

  logic [SAMPLE_BITS-1:0]   view [WINDOW];
  logic [POS_BITS-1:0]      rank [WINDOW];
  logic [SAMPLE_BITS-1:0]   med;

  logic [FRACTION_BITS:0]   inv_weight;
  logic [AW-1:0]            prod_a;
  logic [FRACTION_BITS+AW:0] prod_b;
  logic [AW:0]              sum;
  logic [AW-1:0]            blend;
  logic [AW:0]              rnd;
  logic [SAMPLE_BITS:0]     rnd_int;
  logic [SAMPLE_BITS-1:0]   rounded;

  // ring contents as seen after this transaction's write
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      view[i] = (ctrl.pos == POS_BITS'(i)) ? sample : win_r[i];
    end
  end

  // rank of each entry, ties broken by slot, the middle rank is the median
  always_comb begin
    med = view[0];
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i) begin
          if ((view[j] < view[i]) || ((view[j] == view[i]) && (j < i))) begin
            rank[i] = rank[i] + POS_BITS'(1);
          end
        end
      end
    end
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == POS_BITS'(WINDOW / 2)) begin
        med = view[i];
      end
    end
  end

  // new = w*med + floor((1 - w) * old)
  assign inv_weight = {1'b1, {FRACTION_BITS{1'b0}}} - {1'b0, weight};
  assign prod_a     = AW'(weight) * AW'(med);
  assign prod_b     = (FRACTION_BITS+AW+1)'(inv_weight) * (FRACTION_BITS+AW+1)'(avg_r);
  assign sum        = (AW+1)'(prod_a) + prod_b[FRACTION_BITS +: AW+1];
  assign blend      = sum[AW-1:0];

  // round half up, saturate at full scale
  assign rnd     = {1'b0, blend} + HALF;
  assign rnd_int = rnd[FRACTION_BITS +: SAMPLE_BITS+1];
  assign rounded = rnd_int[SAMPLE_BITS] ? {SAMPLE_BITS{1'b1}} : rnd_int[SAMPLE_BITS-1:0];

  assign avg_nxt  = ctrl.warm ? {sample, {FRACTION_BITS{1'b0}}} : blend;
  assign filtered = ctrl.warm ? sample : rounded;

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      win_r[ctrl.pos] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (ctrl.step) begin
      avg_r <= avg_nxt;
    end
  end

endmodule

[rtl/core/ppg_median_ema_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppg_median_ema_filter
// red / infrared sample filter: 5-tap median followed by a moving average
// ----------------------------------------------------------------------------
// Throughput is one transaction per clock cycle while out_ready keeps the
// result register draining; an accepted transaction is taken into the input
// register and its result into the result register, and a result not yet taken
// holds it in the input register. The cycle time is set by the lane average feedback: the
// (1 - weight) * average multiply and the add of weight * median are
// combinational so that the next sample sees the updated average. For the first
// five samples after reset or after a transaction with restart set,
// warming_up is high and the outputs are the raw samples. The weight register
// on the cfg port may be written only while no transaction is in flight.
module ppg_median_ema_filter import pmef_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // weight configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [WEIGHT_BITS-1:0] cfg_data,
  // sample input
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_red_sample,
  input  logic [SAMPLE_BITS-1:0] in_ir_sample,
  input  logic                   in_restart,
  // filtered output
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_red_filtered,
  output logic [SAMPLE_BITS-1:0] out_ir_filtered,
  output logic                   out_warming_up
);

  localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(WINDOW - 1);

  // configuration
  logic [WEIGHT_BITS-1:0]               weight_r;
  logic [WEIGHT_BITS+FRACTION_BITS-1:0] weight_wide;
  logic [FRACTION_BITS-1:0]             weight_scaled;

  // input register
  logic                   in_vld_r;
  logic [SAMPLE_BITS-1:0] red_r;
  logic [SAMPLE_BITS-1:0] ir_r;
  logic                   restart_r;

  // shared lane control
  logic [POS_BITS-1:0]    pos_r;
  logic [POS_BITS-1:0]    pos_nxt;
  logic [POS_BITS-1:0]    pos_eff;
  logic                   full_r;
  logic                   full_nxt;
  logic                   full_eff;
  logic                   fire;
  lane_ctrl_t             ctrl;

  // result register
  logic                   out_vld_r;
  logic [SAMPLE_BITS-1:0] red_filt_r;
  logic [SAMPLE_BITS-1:0] ir_filt_r;
  logic                   warm_r;
  logic [SAMPLE_BITS-1:0] red_filt;
  logic [SAMPLE_BITS-1:0] ir_filt;

  // weight register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_valid) begin
      weight_r <= cfg_data;
    end
  end

  // rescale the Q0.16 weight to the lane fraction width (truncating)
  assign weight_wide   = {weight_r, {FRACTION_BITS{1'b0}}};
  assign weight_scaled = weight_wide[WEIGHT_BITS+FRACTION_BITS-1 -: FRACTION_BITS];

  // process the held transaction when the result register is free or draining
  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      red_r     <= in_red_sample;
      ir_r      <= in_ir_sample;
      restart_r <= in_restart;
    end
  end

  // restart clears position and full flag before the sample is written
  assign pos_eff  = restart_r ? '0 : pos_r;
  assign full_eff = restart_r ? 1'b0 : full_r;
  assign pos_nxt  = (pos_eff == LAST_POS) ? '0 : pos_eff + POS_BITS'(1);
  assign full_nxt = full_eff || (pos_eff == LAST_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      full_r <= 1'b0;
    end else if (fire) begin
      pos_r  <= pos_nxt;
      full_r <= full_nxt;
    end
  end

  assign ctrl.step = fire;
  assign ctrl.warm = !full_eff;
  assign ctrl.pos  = pos_eff;

  pmef_lane #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_red_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .sample   (red_r),
    .weight   (weight_scaled),
    .filtered (red_filt)
  );

  pmef_lane #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ir_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .sample   (ir_r),
    .weight   (weight_scaled),
    .filtered (ir_filt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      red_filt_r <= red_filt;
      ir_filt_r  <= ir_filt;
      warm_r     <= ctrl.warm;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_red_filtered = red_filt_r;
  assign out_ir_filtered  = ir_filt_r;
  assign out_warming_up   = warm_r;

  // write position stays inside the ring
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("ring position out of range");

  // the full flag only sets on a commit that writes the last slot
  a_full_set: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full_r) |-> $past(fire && (pos_eff == LAST_POS)))
    else $error("full flag set without writing last slot");

  // a processed transaction always lands in the result register
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed transaction lost");

  // input stalls only while a transaction is held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without cause");

endmodule
